// ===== sv/skmt_pkg.sv =====
package skmt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_W       = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ECNT_W      = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic              found;
		logic              status;
		logic [ECNT_W-1:0] entry_count;
	} result_t;

	// command broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             look;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// neighbor link, left cell to right cell
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             gt;
		logic             occ;
	} link_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_REDUCE = 3'b100
	} state_t;

	// count reported modulo 2**ECNT_W
	function automatic logic [ECNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+ECNT_W-1:0] ext;
		ext = {{ECNT_W{1'b0}}, cnt};
		return ext[ECNT_W-1:0];
	endfunction

endpackage

// ===== sv/skmt_cell.sv =====
module skmt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  skmt_pkg::cmd_t   cmd,
	input  logic             occ,
	input  skmt_pkg::link_t  left,
	output skmt_pkg::link_t  right,
	output logic             hit
);
	import skmt_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic             hit_q;
	logic             gt;
	logic             at_end;

	// key above the new one: this cell shifts up; first free cell also takes a key
	assign gt     = occ && (key_q > cmd.key);
	assign at_end = !occ && left.occ;

	always_ff @(posedge clk) begin
		if (cmd.ins && (gt || at_end)) begin
			key_q <= left.gt ? left.key : cmd.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= cmd.look && occ && (key_q == cmd.key);
		end
	end

	assign right.key = key_q;
	assign right.gt  = gt;
	assign right.occ = occ;
	assign hit       = hit_q;

endmodule

// ===== sv/sorted_key_membership_table_unit.sv =====
// Sorted key membership table: up to TABLE_DEPTH 64-bit keys kept in
// ascending order in a row of cells, one key per cell.
//
// Input: a transaction is taken at a rising edge with start high and busy
// low. item.action selects insert or lookup, item.key is the key.
// Output: done is high for exactly one cycle with result valid. The
// receiver cannot stall; the result is gone after that cycle.
//
// Sequence: after the accept edge, the EXEC state has all cells compare against
// the key at once (and on insert, every larger key moves up one cell while
// the new key drops into place); the REDUCE state then ORs the registered
// per-cell hit flags. done rises the cycle after that; busy is high in EXEC and REDUCE.
// A new transaction may be accepted at the edge that ends the done cycle,
// so the block takes no new item before it is through with the last one.
//
// Inserts into a full table are dropped with status set. Duplicate keys are
// stored side by side. Reset empties the table (count to zero); cell
// contents are not cleared, occupancy comes from the count.
module sorted_key_membership_table_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  skmt_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output skmt_pkg::result_t result
);
	import skmt_pkg::*;

	state_t           state_q;
	item_t            item_q;
	logic [CNT_W-1:0] count_q;
	logic             status_q;
	logic             done_q;
	result_t          result_q;

	cmd_t                   cmd;
	logic [TABLE_DEPTH-1:0] occ;
	logic [TABLE_DEPTH-1:0] hit;
	link_t                  link [TABLE_DEPTH+1];
	logic                   full;
	logic                   in_take;

	assign in_take = start && (state_q == S_IDLE);
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));

	assign cmd.ins  = (state_q == S_EXEC) && (item_q.action == ACT_INSERT) && !full;
	assign cmd.look = (state_q == S_EXEC) && (item_q.action == ACT_LOOKUP);
	assign cmd.key  = item_q.key;

	// left edge of the chain: nothing larger, treated as occupied
	assign link[0].key = '0;
	assign link[0].gt  = 1'b0;
	assign link[0].occ = 1'b1;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CNT_W'(i));

		skmt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.occ    (occ[i]),
			.left   (link[i]),
			.right  (link[i+1]),
			.hit    (hit[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ((item_q.action == ACT_INSERT) && full) ? ST_FULL : ST_DONE;
					if (cmd.ins) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, valid while done is high
	always_ff @(posedge clk) begin
		if (state_q == S_REDUCE) begin
			result_q.found       <= |hit;
			result_q.status      <= status_q;
			result_q.entry_count <= to_entry_count(count_q);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("count above table depth");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction taken but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |->
			!result.found && (result.entry_count == to_entry_count(CNT_W'(TABLE_DEPTH))))
		else $error("rejected insert with wrong result");

	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REDUCE) && (item_q.action == ACT_INSERT) |-> (hit == '0))
		else $error("hit flag on insert");

endmodule

// ===== sim/sorted_key_membership_table_unit_tb.sv =====
module sorted_key_membership_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skmt_pkg::*;

	localparam int RANDOM_ITEMS = 1430;
	localparam int STALL_LIMIT  = 2000;   // cycles with no transaction at all

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;

	sorted_key_membership_table_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// stimulus side
	item_t   stim_items[$];
	int      n_total = 0;
	int      n_sent = 0;
	logic    took = 1'b0;        // start was taken at the last rising edge

	// checking side
	result_t pending_answers[$];
	int      err_count = 0;
	int      stall_cycles = 0;

	// shadow table: ascending keys, only the low shadow_count cells valid
	logic [KEY_W-1:0] shadow_keys[TABLE_DEPTH];
	int               shadow_count = 0;

	// keys the generator knows are stored, for hits, duplicates and near misses
	logic [KEY_W-1:0] gen_keys[$];

	// Apply one transaction to the shadow table and return the answer it owes.
	task automatic table_apply(input item_t it, output result_t ans);
		int pos;
		ans = '0;
		ans.status = ST_DONE;
		if (it.action == ACT_INSERT) begin
			if (shadow_count >= TABLE_DEPTH) begin
				// full: dropped and flagged, count unchanged
				ans.status = ST_FULL;
			end else begin
				// walk down from the top, moving strictly larger keys up one cell;
				// an equal key stops the walk so duplicates sit side by side
				pos = shadow_count;
				while (pos > 0 && shadow_keys[pos-1] > it.key) begin
					shadow_keys[pos] = shadow_keys[pos-1];
					pos--;
				end
				shadow_keys[pos] = it.key;
				shadow_count++;
			end
		end else begin
			// lookup never touches the table; an empty table never hits
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_keys[i] == it.key)
					ans.found = 1'b1;
			end
		end
		ans.entry_count = shadow_count[ECNT_W-1:0];
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic add_insert(input logic [KEY_W-1:0] k);
		item_t it;
		it.action = ACT_INSERT;
		it.key    = k;
		stim_items.insert(stim_items.size(), it);
		if (gen_keys.size() < TABLE_DEPTH)
			gen_keys.insert(gen_keys.size(), k);
	endtask

	task automatic add_lookup(input logic [KEY_W-1:0] k);
		item_t it;
		it.action = ACT_LOOKUP;
		it.key    = k;
		stim_items.insert(stim_items.size(), it);
	endtask

	function automatic logic [KEY_W-1:0] stored_key();
		return gen_keys[$urandom_range(gen_keys.size() - 1, 0)];
	endfunction

	// Driver: a raised start is held with the same item until it is taken.
	// Before each new transaction the sender may idle instead; the chance is
	// 10 % over the first third of the run, 60 % over the second, none after.
	always @(negedge clk) begin
		int idle_pct;
		if (arst_n) begin
			if (n_sent < n_total / 3)
				idle_pct = 10;
			else if (n_sent < (2 * n_total) / 3)
				idle_pct = 60;
			else
				idle_pct = 0;
			if (start && !took) begin
				// still waiting on busy, hold everything
			end else if (stim_items.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
				start <= 1'b1;
				item  <= stim_items.pop_front();
				n_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: done is checked before the same edge's new transaction is
	// queued, since that strobe always belongs to an older transaction.
	always @(posedge clk) begin
		result_t ans;
		result_t want;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (pending_answers.size() == 0) begin
					$error("result with no transaction outstanding: %p", result);
					err_count++;
				end else begin
					want = pending_answers.pop_front();
					if (result.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, result.found);
						err_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						err_count++;
					end
					if (result.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, result.entry_count);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				table_apply(item, ans);
				pending_answers.insert(pending_answers.size(), ans);
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: too long without any transaction moving either way.
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("** sorted_key_membership_table_unit: FAILED **");
		$finish;
	end

	initial begin
		int               r;
		int               sel;
		logic [KEY_W-1:0] k;

		// directed: empty-table lookups, extremes, duplicates, hits and misses
		add_lookup('0);
		add_lookup('1);
		add_insert('1);
		add_insert('0);
		add_insert('1);                         // duplicate of the top key
		add_insert({1'b1, {(KEY_W-1){1'b0}}});
		add_lookup('0);
		add_lookup('1);
		add_lookup(64'd1);
		add_lookup(~64'd1);
		add_lookup({1'b1, {(KEY_W-1){1'b0}}});
		add_lookup({1'b0, {(KEY_W-1){1'b1}}});  // miss just below a stored key
		add_insert({1'b0, {(KEY_W-1){1'b1}}});  // lands mid-table
		add_insert(64'd5);
		add_insert(64'd5);                      // duplicate in the middle
		add_insert(64'd4);
		add_lookup({1'b0, {(KEY_W-1){1'b1}}});
		add_lookup(64'd5);
		add_lookup(64'd6);
		add_lookup(64'd4);
		add_lookup(64'd3);
		add_insert(64'h5555_5555_5555_5555);
		add_insert(64'hAAAA_AAAA_AAAA_AAAA);
		add_lookup(64'h5555_5555_5555_5555);
		add_lookup(64'hAAAA_AAAA_AAAA_AAAA);

		// random: inserts stay sparse so the table fills over roughly the first
		// third of the run; later inserts all land on a full table
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r   = $urandom_range(99, 0);
			sel = $urandom_range(9, 0);
			if (r < ((gen_keys.size() < TABLE_DEPTH) ? 15 : 10)) begin
				if (sel < 3)
					k = stored_key();
				else if (sel < 5)
					k = KEY_W'($urandom_range(15, 0));
				else if (sel == 5)
					k = $urandom_range(1, 0) ? '1 : '0;
				else
					k = rand_key();
				add_insert(k);
			end else begin
				if (sel < 5)
					k = stored_key();
				else if (sel < 7)
					k = $urandom_range(1, 0) ? stored_key() + 1'b1 : stored_key() - 1'b1;
				else if (sel == 7)
					k = $urandom_range(1, 0) ? '1 : '0;
				else
					k = rand_key();
				add_lookup(k);
			end
		end
		n_total = stim_items.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: everything sent, start dropped, every answer back
		while (stim_items.size() > 0 || start || pending_answers.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0 && pending_answers.size() == 0)
			$display("** sorted_key_membership_table_unit: PASSED **");
		else
			$display("** sorted_key_membership_table_unit: FAILED **");
		$finish;
	end

endmodule
